/* design/fpgm_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the farthest-pair greedy matcher.
// No dependencies; imported by the datapath, the top level and the checker.
package fpgm_pkg;

  localparam int unsigned COORD_W  = 16;
  localparam int unsigned CNT_W    = 6;
  localparam int unsigned OIDX_W   = 6;
  localparam int unsigned DIST_W   = 2 * COORD_W + 1;
  localparam int unsigned PAIR_MAX = 32;

  localparam logic [CNT_W-1:0] PAIR_COUNT_RST = 6'd1;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  typedef logic [COORD_W-1:0]   coord_t;
  typedef logic [2*COORD_W-1:0] pos_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_CHECK,
    ST_ERR,
    ST_SCAN_I,
    ST_LATCH_I,
    ST_SCAN_J,
    ST_DRAIN,
    ST_EMIT
  } state_e;

endpackage

/* design/fpgm_ram.sv */
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module fpgm_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* design/fpgm_dist_pipe.sv */
`timescale 1ns / 1ps
// Squared-distance pipeline and running best-pair tracker.
// Depends on fpgm_pkg. Takes the pair tag when the RAM read is issued.
module fpgm_dist_pipe #(
  parameter int unsigned IW = 6
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            clear_i,
  input  logic            issue_i,
  input  logic [IW-1:0]   src_i,
  input  logic [IW-1:0]   dst_i,
  input  fpgm_pkg::pos_t  pos_a_i,
  input  fpgm_pkg::pos_t  pos_b_i,
  output logic            busy_o,
  output logic [IW-1:0]   best_src_o,
  output logic [IW-1:0]   best_dst_o
);

  import fpgm_pkg::*;

  // stage 0: tag waits for the RAM word
  logic          s0_v_q;
  logic [IW-1:0] s0_src_q, s0_dst_q;
  // stage 1: absolute differences
  logic          s1_v_q;
  logic [IW-1:0] s1_src_q, s1_dst_q;
  coord_t        dx_q, dy_q;
  // stage 2: squares
  logic                 s2_v_q;
  logic [IW-1:0]        s2_src_q, s2_dst_q;
  logic [2*COORD_W-1:0] sqx_q, sqy_q;
  // best so far
  logic              found_q;
  logic [DIST_W-1:0] best_q;
  logic [IW-1:0]     bs_q, bd_q;

  coord_t            ax, ay, bx, by, dx_d, dy_d;
  logic [DIST_W-1:0] sum;
  logic              take;

  always_comb begin
    ax   = pos_a_i[COORD_W-1:0];
    ay   = pos_a_i[2*COORD_W-1:COORD_W];
    bx   = pos_b_i[COORD_W-1:0];
    by   = pos_b_i[2*COORD_W-1:COORD_W];
    dx_d = (ax > bx) ? ax - bx : bx - ax;
    dy_d = (ay > by) ? ay - by : by - ay;
    sum  = {1'b0, sqx_q} + {1'b0, sqy_q};
    // scan order is ascending (i,j), so strict greater keeps the tie rule
    take = s2_v_q && (!found_q || sum > best_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_v_q  <= 1'b0;
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      found_q <= 1'b0;
    end else begin
      s0_v_q <= issue_i;
      s1_v_q <= s0_v_q;
      s2_v_q <= s1_v_q;
      if (clear_i) begin
        found_q <= 1'b0;
      end else if (take) begin
        found_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    s0_src_q <= src_i;
    s0_dst_q <= dst_i;
    s1_src_q <= s0_src_q;
    s1_dst_q <= s0_dst_q;
    dx_q     <= dx_d;
    dy_q     <= dy_d;
    s2_src_q <= s1_src_q;
    s2_dst_q <= s1_dst_q;
    sqx_q    <= (2*COORD_W)'(dx_q) * (2*COORD_W)'(dx_q);
    sqy_q    <= (2*COORD_W)'(dy_q) * (2*COORD_W)'(dy_q);
    if (take) begin
      best_q <= sum;
      bs_q   <= s2_src_q;
      bd_q   <= s2_dst_q;
    end
  end

  assign busy_o     = s0_v_q | s1_v_q | s2_v_q;
  assign best_src_o = bs_q;
  assign best_dst_o = bd_q;

endmodule

/* design/farthest_pair_greedy_matcher.sv */
`timescale 1ns / 1ps
// Farthest-pair greedy matcher, top level. Loading takes one node word per cycle.
// A last-node word starts selection: each round scans all unused pairs. There are
// pair_count rounds per set, with a check state first. A refused request passes
// the check and error states before its error word is registered on the output.
// Reset (async, active low) clears node count, used flags and state; pair_count = 1.
module farthest_pair_greedy_matcher #(
  parameter int unsigned MAX_NODES = 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  fpgm_pkg::coord_t                  pos_x_i,
  input  fpgm_pkg::coord_t                  pos_y_i,
  input  logic                              last_node_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [fpgm_pkg::OIDX_W-1:0]       source_index_o,
  output logic [fpgm_pkg::OIDX_W-1:0]       dest_index_o,
  output logic                              status_o,
  output logic                              last_pair_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [fpgm_pkg::CNT_W-1:0]        pair_count_i
);

  import fpgm_pkg::*;

  localparam int unsigned IW = $clog2(MAX_NODES);
  localparam int unsigned CW = $clog2(MAX_NODES + 1);
  localparam int unsigned KW = (CW > CNT_W + 1) ? CW : CNT_W + 1;

  state_e state_q, state_d;
  logic [CW-1:0]        n_q, n_d, i_q, i_d, j_q, j_d;
  logic [CNT_W-1:0]     round_q, round_d, want_q;
  logic [MAX_NODES-1:0] used_q, used_d;
  pos_t                 pos_src_q, pos_src_d;

  logic              out_valid_q, out_valid_d, out_load;
  logic [OIDX_W-1:0] src_q, src_d, dst_q, dst_d;
  logic              status_q, status_d, last_q, last_d;

  logic          ram_we, ram_re, issue, pipe_clear, pipe_busy;
  logic [IW-1:0] ram_raddr, best_src, best_dst;
  pos_t          ram_rdata;

  logic in_fire, out_free, i_used, j_used, i_end, j_end, bad_req, last_round;
  logic [CNT_W:0]           two_want;
  logic [IW+OIDX_W-1:0]     bs_ext, bd_ext;

  assign in_ready_o  = (state_q == ST_LOAD);
  assign cfg_ready_o = 1'b1;
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign i_used      = used_q[i_q[IW-1:0]];
  assign j_used      = used_q[j_q[IW-1:0]];
  assign i_end       = (i_q + CW'(1)) >= n_q;
  assign j_end       = j_q >= n_q;
  assign two_want    = {want_q, 1'b0};
  assign bad_req     = (want_q == '0) || (want_q > CNT_W'(PAIR_MAX)) ||
                       (KW'(two_want) > KW'(n_q));
  assign last_round  = (round_q + CNT_W'(1)) == want_q;
  assign bs_ext      = {{OIDX_W{1'b0}}, best_src};
  assign bd_ext      = {{OIDX_W{1'b0}}, best_dst};

  fpgm_ram #(
    .WIDTH (2 * COORD_W),
    .DEPTH (MAX_NODES)
  ) u_pos_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (n_q[IW-1:0]),
    .wdata_i ({pos_y_i, pos_x_i}),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  fpgm_dist_pipe #(
    .IW (IW)
  ) u_dist (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .clear_i    (pipe_clear),
    .issue_i    (issue),
    .src_i      (i_q[IW-1:0]),
    .dst_i      (j_q[IW-1:0]),
    .pos_a_i    (pos_src_q),
    .pos_b_i    (ram_rdata),
    .busy_o     (pipe_busy),
    .best_src_o (best_src),
    .best_dst_o (best_dst)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_LOAD: begin
        if (in_fire && last_node_i) state_d = ST_CHECK;
      end
      ST_CHECK: begin
        state_d = bad_req ? ST_ERR : ST_SCAN_I;
      end
      ST_ERR: begin
        if (out_free) state_d = ST_LOAD;
      end
      ST_SCAN_I: begin
        if (i_end) state_d = ST_DRAIN;
        else if (!i_used) state_d = ST_LATCH_I;
      end
      ST_LATCH_I: begin
        state_d = ST_SCAN_J;
      end
      ST_SCAN_J: begin
        if (j_end) state_d = ST_SCAN_I;
      end
      ST_DRAIN: begin
        if (!pipe_busy) state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) state_d = last_round ? ST_LOAD : ST_SCAN_I;
      end
      default: state_d = ST_LOAD;
    endcase
  end

  // datapath and outputs
  always_comb begin
    n_d        = n_q;
    i_d        = i_q;
    j_d        = j_q;
    round_d    = round_q;
    used_d     = used_q;
    pos_src_d  = pos_src_q;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    ram_raddr  = i_q[IW-1:0];
    issue      = 1'b0;
    pipe_clear = 1'b0;
    out_load   = 1'b0;
    src_d      = src_q;
    dst_d      = dst_q;
    status_d   = status_q;
    last_d     = last_q;
    unique case (state_q)
      ST_LOAD: begin
        // a full store drops the word and keeps the count saturated
        if (in_fire && (n_q != CW'(MAX_NODES))) begin
          ram_we = 1'b1;
          n_d    = n_q + CW'(1);
        end
      end
      ST_CHECK: begin
        i_d        = '0;
        round_d    = '0;
        used_d     = '0;
        pipe_clear = 1'b1;
      end
      ST_ERR: begin
        if (out_free) begin
          out_load = 1'b1;
          src_d    = '0;
          dst_d    = '0;
          status_d = STATUS_ERR;
          last_d   = 1'b1;
          n_d      = '0;
        end
      end
      ST_SCAN_I: begin
        if (!i_end) begin
          if (i_used) begin
            i_d = i_q + CW'(1);
          end else begin
            ram_re = 1'b1;
            j_d    = i_q + CW'(1);
          end
        end
      end
      ST_LATCH_I: begin
        pos_src_d = ram_rdata;
      end
      ST_SCAN_J: begin
        if (j_end) begin
          i_d = i_q + CW'(1);
        end else begin
          j_d       = j_q + CW'(1);
          ram_raddr = j_q[IW-1:0];
          if (!j_used) begin
            ram_re = 1'b1;
            issue  = 1'b1;
          end
        end
      end
      ST_DRAIN: begin
      end
      ST_EMIT: begin
        if (out_free) begin
          out_load         = 1'b1;
          src_d            = bs_ext[OIDX_W-1:0];
          dst_d            = bd_ext[OIDX_W-1:0];
          status_d         = STATUS_OK;
          last_d           = last_round;
          used_d[best_src] = 1'b1;
          used_d[best_dst] = 1'b1;
          round_d          = round_q + CNT_W'(1);
          i_d              = '0;
          pipe_clear       = 1'b1;
          if (last_round) begin
            n_d    = '0;
            used_d = '0;
          end
        end
      end
      default: begin
      end
    endcase
    out_valid_d = out_load ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      n_q         <= '0;
      used_q      <= '0;
      want_q      <= PAIR_COUNT_RST;
      out_valid_q <= 1'b0;
      i_q         <= '0;
      j_q         <= '0;
      round_q     <= '0;
    end else begin
      state_q     <= state_d;
      n_q         <= n_d;
      used_q      <= used_d;
      out_valid_q <= out_valid_d;
      i_q         <= i_d;
      j_q         <= j_d;
      round_q     <= round_d;
      if (cfg_valid_i && cfg_ready_o) begin
        want_q <= pair_count_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pos_src_q <= pos_src_d;
    src_q     <= src_d;
    dst_q     <= dst_d;
    status_q  <= status_d;
    last_q    <= last_d;
  end

  assign out_valid_o    = out_valid_q;
  assign source_index_o = src_q;
  assign dest_index_o   = dst_q;
  assign status_o       = status_q;
  assign last_pair_o    = last_q;

endmodule

/* design/fpgm_checker.sv */
`timescale 1ns / 1ps
// Port-level checker for the farthest-pair greedy matcher, bound to the top level.
// Depends on fpgm_pkg.
module fpgm_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_o,
  input logic                        last_node_i,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input logic [fpgm_pkg::OIDX_W-1:0] source_index_o,
  input logic [fpgm_pkg::OIDX_W-1:0] dest_index_o,
  input logic                        status_o,
  input logic                        last_pair_o
);

  import fpgm_pkg::*;

  // result word holds while stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(source_index_o) &&
    $stable(dest_index_o) && $stable(status_o) && $stable(last_pair_o))
  else $error("result word changed while stalled");

  // error word is always a lone, final result with zero indices
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == STATUS_ERR) |->
    last_pair_o && (source_index_o == '0) && (dest_index_o == '0))
  else $error("malformed error result");

  // no loading while a run is still going
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_pair_o |-> !in_ready_o)
  else $error("input accepted mid-run");

  // a last-node word starts selection at once
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && last_node_i |=> !in_ready_o)
  else $error("loading continued after last node");

endmodule

bind farthest_pair_greedy_matcher fpgm_checker u_fpgm_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_ready_o     (in_ready_o),
  .last_node_i    (last_node_i),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .source_index_o (source_index_o),
  .dest_index_o   (dest_index_o),
  .status_o       (status_o),
  .last_pair_o    (last_pair_o)
);

/* tb/farthest_pair_greedy_matcher_test.sv */
`timescale 1ns / 1ps
// Self-checking testbench for farthest_pair_greedy_matcher: node sets in, greedy pairs out.
// Depends on fpgm_pkg and the matcher RTL; a small class predicts and checks the pairs.
module farthest_pair_greedy_matcher_test;
  import fpgm_pkg::*;

  localparam int unsigned NODE_SLOTS   = 64;
  localparam int unsigned LIMIT_CYCLES = 1_500_000;
  localparam int unsigned DRAIN_CYCLES = 16;
  localparam int unsigned MAX_REPORTS  = 10;

  localparam int unsigned IDLE_NONE = 0;
  localparam int unsigned IDLE_SEND = 1;
  localparam int unsigned IDLE_RECV = 2;
  localparam int unsigned IDLE_BOTH = 3;

  localparam int unsigned STYLE_WIDE    = 0;
  localparam int unsigned STYLE_CLUSTER = 1;
  localparam int unsigned STYLE_CORNER  = 2;

  typedef struct packed {
    logic [OIDX_W-1:0] src;
    logic [OIDX_W-1:0] dst;
    logic              status;
    logic              last;
  } pair_t;

  // Holds the node store of the current set and the pairs still owed by the block.
  class pair_book;
    pos_t              nodes[NODE_SLOTS];
    int unsigned       loaded;
    logic [CNT_W-1:0]  pair_count;
    pair_t             pending[$];
    int unsigned       errors;
    int unsigned       checked;
    int unsigned       refusals;

    function new();
      loaded     = 0;
      pair_count = PAIR_COUNT_RST;
      errors     = 0;
      checked    = 0;
      refusals   = 0;
    endfunction

    function void set_pair_count(input logic [CNT_W-1:0] value);
      pair_count = value;
    endfunction

    function int unsigned pending_words();
      return pending.size();
    endfunction

    function automatic logic [DIST_W-1:0] span2(input pos_t a, input pos_t b);
      logic [DIST_W-1:0] dx, dy;
      dx = (a[COORD_W-1:0] > b[COORD_W-1:0]) ? a[COORD_W-1:0] - b[COORD_W-1:0]
                                              : b[COORD_W-1:0] - a[COORD_W-1:0];
      dy = (a[2*COORD_W-1:COORD_W] > b[2*COORD_W-1:COORD_W])
           ? a[2*COORD_W-1:COORD_W] - b[2*COORD_W-1:COORD_W]
           : b[2*COORD_W-1:COORD_W] - a[2*COORD_W-1:COORD_W];
      return dx * dx + dy * dy;
    endfunction

    // Accepted node word; the last one of a set yields the whole list of pairs, or one error word on a refused request.
    function void take_node(input coord_t x, input coord_t y, input logic last);
      logic [NODE_SLOTS-1:0] used;
      logic [DIST_W-1:0]     best, d;
      int unsigned           bs, bd;
      bit                    found;
      pair_t                 p;
      if (loaded < NODE_SLOTS) begin
        nodes[loaded] = {y, x};
        loaded++;
      end
      if (!last) return;
      if (pair_count == 0 || pair_count > PAIR_MAX || 2 * int'(pair_count) > loaded) begin
        p = '{src: '0, dst: '0, status: STATUS_ERR, last: 1'b1};
        pending = {pending, p};
        refusals++;
      end else begin
        used = '0;
        for (int unsigned r = 0; r < pair_count; r++) begin
          found = 0;
          best  = '0;
          bs    = 0;
          bd    = 0;
          for (int unsigned i = 0; i < loaded; i++) begin
            if (used[i]) continue;
            for (int unsigned j = i + 1; j < loaded; j++) begin
              if (used[j]) continue;
              d = span2(nodes[i], nodes[j]);
              // ascending scan, so strict compare keeps the lower-index tie winner
              if (!found || d > best) begin
                found = 1;
                best  = d;
                bs    = i;
                bd    = j;
              end
            end
          end
          used[bs] = 1'b1;
          used[bd] = 1'b1;
          p = '{src: bs[OIDX_W-1:0], dst: bd[OIDX_W-1:0], status: STATUS_OK,
                last: (r + 1 == pair_count)};
          pending = {pending, p};
        end
      end
      loaded = 0;
    endfunction

    function void note_fail(input string msg);
      errors++;
      if (errors <= MAX_REPORTS) $display("MISMATCH: %s", msg);
    endfunction

    function void check_pair(input pair_t got);
      pair_t want;
      checked++;
      if (pending.size() == 0) begin
        note_fail($sformatf("unexpected word src=%0d dst=%0d status=%0b last=%0b",
                            got.src, got.dst, got.status, got.last));
        return;
      end
      want = pending.pop_front();
      if (got.src !== want.src || got.dst !== want.dst ||
          got.status !== want.status || got.last !== want.last)
        note_fail($sformatf({"expected src=%0d dst=%0d status=%0b last=%0b, ",
                             "got src=%0d dst=%0d status=%0b last=%0b"},
                            want.src, want.dst, want.status, want.last,
                            got.src, got.dst, got.status, got.last));
    endfunction
  endclass

  logic              clk_i          = 1'b0;
  logic              rst_ni         = 1'b0;
  logic              in_valid_i     = 1'b0;
  logic              in_ready_o;
  coord_t            pos_x_i        = '0;
  coord_t            pos_y_i        = '0;
  logic              last_node_i    = 1'b0;
  logic              out_valid_o;
  logic              out_ready_i    = 1'b0;
  logic [OIDX_W-1:0] source_index_o;
  logic [OIDX_W-1:0] dest_index_o;
  logic              status_o;
  logic              last_pair_o;
  logic              cfg_valid_i    = 1'b0;
  logic              cfg_ready_o;
  logic [CNT_W-1:0]  pair_count_i   = '0;

  pair_book    book = new();
  int unsigned cycles        = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned nodes_sent    = 0;
  int unsigned sets_run      = 0;

  farthest_pair_greedy_matcher #(
    .MAX_NODES(NODE_SLOTS)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .pos_x_i       (pos_x_i),
    .pos_y_i       (pos_y_i),
    .last_node_i   (last_node_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .source_index_o(source_index_o),
    .dest_index_o  (dest_index_o),
    .status_o      (status_o),
    .last_pair_o   (last_pair_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .pair_count_i  (pair_count_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles, %0d words still owed", cycles, book.pending_words());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      book.check_pair('{src: source_index_o, dst: dest_index_o,
                        status: status_o, last: last_pair_o});
  end

  function automatic void set_idle(input int unsigned mode);
    case (mode)
      IDLE_SEND: begin send_idle_pct = 75; recv_stall_pct = 0;  end
      IDLE_RECV: begin send_idle_pct = 0;  recv_stall_pct = 75; end
      IDLE_BOTH: begin send_idle_pct = 36; recv_stall_pct = 36; end
      default:   begin send_idle_pct = 0;  recv_stall_pct = 0;  end
    endcase
  endfunction

  function automatic coord_t pick_coord(input int unsigned style);
    case (style)
      STYLE_CLUSTER: return coord_t'($urandom_range(0, 3));
      STYLE_CORNER:  return $urandom_range(0, 1) ? '1 : '0;
      default:       return coord_t'($urandom_range(0, 65535));
    endcase
  endfunction

  // valid is left high after acceptance; the next word or an idle cycle decides
  task automatic send_node(input coord_t x, input coord_t y, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    pos_x_i     <= x;
    pos_y_i     <= y;
    last_node_i <= last;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    book.take_node(x, y, last);
    nodes_sent++;
  endtask

  task automatic send_set(input int unsigned n, input int unsigned style);
    for (int unsigned k = 0; k < n; k++)
      send_node(pick_coord(style), pick_coord(style), k == n - 1);
    sets_run++;
  endtask

  task automatic write_pair_count(input logic [CNT_W-1:0] value);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (book.pending_words() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    cfg_valid_i  <= 1'b1;
    pair_count_i <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    book.set_pair_count(value);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    int unsigned       sent, n;
    logic [CNT_W-1:0]  pc;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed sets at the reset pair count of one.
    set_idle(IDLE_NONE);
    send_node(16'h0000, 16'h0000, 1'b0);     // full-scale diagonal
    send_node(16'hFFFF, 16'hFFFF, 1'b1);
    send_node(16'd1234, 16'd5678, 1'b1);     // lone node: too few
    repeat (3) send_node(16'd7, 16'd7, 1'b0); // all coincident
    send_node(16'd7, 16'd7, 1'b1);
    send_node(16'd0, 16'd0, 1'b0);           // equal distances, lower dest wins
    send_node(16'd3, 16'd4, 1'b0);
    send_node(16'd4, 16'd3, 1'b1);
    send_node(16'h0000, 16'h0000, 1'b0);     // far pair excludes node 0
    send_node(16'hFFFF, 16'h0000, 1'b0);
    send_node(16'h0000, 16'hFFFF, 1'b1);
    sets_run += 5;

    write_pair_count('0);                    // zero pairs asked: refused
    send_node(16'd1, 16'd1, 1'b0);
    send_node(16'd2, 16'd2, 1'b0);
    send_node(16'd3, 16'd3, 1'b1);
    write_pair_count('1);                    // beyond the pair limit: refused
    send_node(16'd0, 16'd0, 1'b0);
    send_node(16'd1, 16'd1, 1'b1);
    write_pair_count(CNT_W'(2));
    send_node(16'd0, 16'd0, 1'b0);           // tie on distance, lower source first
    send_node(16'd100, 16'd0, 1'b0);
    send_node(16'd0, 16'd1, 1'b0);
    send_node(16'd100, 16'd1, 1'b1);
    send_node(16'd5, 16'd5, 1'b0);           // three nodes for two pairs
    send_node(16'd6, 16'd6, 1'b0);
    send_node(16'd7, 16'd7, 1'b1);
    sets_run += 4;

    // Random phases: pair count and idling change between them.
    for (int unsigned ph = 0; ph < 8; ph++) begin
      case (ph)
        0:       pc = CNT_W'(1);
        1:       pc = CNT_W'(PAIR_MAX);
        2:       pc = CNT_W'($urandom_range(2, 8));
        3:       pc = CNT_W'($urandom_range(33, 63));
        4:       pc = CNT_W'($urandom_range(1, 12));
        5:       pc = CNT_W'($urandom_range(2, 6));
        6:       pc = CNT_W'($urandom_range(9, 12));
        default: pc = CNT_W'($urandom_range(1, 8));
      endcase
      write_pair_count(pc);
      set_idle(ph % 4);
      // overfilled store: the closing word is dropped but still starts selection
      if (ph == 1) send_set(NODE_SLOTS + 1, STYLE_WIDE);
      sent = 0;
      while (sent < 4) begin
        if (pc >= 1 && pc <= 12 && $urandom_range(99) < 85)
          n = 2 * pc + $urandom_range(0, 4);
        else
          n = $urandom_range(1, 8);
        send_set(n, $urandom_range(STYLE_WIDE, STYLE_CORNER));
        sent += n;
      end
    end

    in_valid_i <= 1'b0;
    while (book.pending_words() != 0) @(posedge clk_i);
    repeat (4 * DRAIN_CYCLES) @(posedge clk_i);

    $display("Covered %0d node words in %0d sets, %0d result words checked (%0d refusals).",
             nodes_sent, sets_run, book.checked, book.refusals);
    $display("Pair counts spanned zero to 63, with idle and stall patterns on both sides.");
    if (book.errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

/* files.f */
design/fpgm_pkg.sv
design/fpgm_ram.sv
design/fpgm_dist_pipe.sv
design/farthest_pair_greedy_matcher.sv
design/fpgm_checker.sv
tb/farthest_pair_greedy_matcher_test.sv
